@@ src/gpe_pkg.sv @@
// Shared types and constants for the glyph pair expander.
// No dependencies; imported by every module of the block except gpe_ram.
`default_nettype none
package gpe_pkg;

  // default pair table depth
  localparam int TABLE_DEPTH_DEF = 1024;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_FIRST_GLYPH = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PAIR_COUNT  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CAPACITY    = 2'd2;
  localparam logic [15:0] CAPACITY_RESET = 16'd256;

  // request opcodes carried in tuser
  localparam logic OP_TABLE = 1'b0;
  localparam logic OP_TEXT  = 1'b1;

  // input tdata layout
  localparam int IN_TDATA_W = 56;
  localparam int IDX_LSB    = 0;
  localparam int FIRST_LSB  = 10;
  localparam int SECOND_LSB = 26;
  localparam int TEXT_LSB   = 42;

  // byte constants
  localparam logic [7:0] LEAD_MARK = 8'h80;
  localparam logic [6:0] CODE_HI_MASK = 7'h7F;

  // one queued command: cnt data bytes, then the terminator if term is set
  typedef struct packed {
    logic [2:0]      cnt;
    logic            pair;
    logic            term;
    logic            ovf;
    logic [3:0][7:0] data;
  } gpe_cmd_t;

endpackage
`default_nettype wire

@@ src/gpe_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
`default_nettype none
module gpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // storage write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ src/gpe_front.sv @@
// Front end: config registers, request decode, length and overflow tracking,
// pair table lookup. Depends on gpe_pkg and gpe_ram.
`default_nettype none
module gpe_front #(
  parameter int TABLE_DEPTH = gpe_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gpe_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [gpe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_accept,
  input  logic [gpe_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [0:0]                      in_tuser,
  output logic                            push,
  output gpe_pkg::gpe_cmd_t               push_cmd
);
  import gpe_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [16:0] DEPTH_L = 17'(TABLE_DEPTH);

  logic [14:0] first_glyph_r;
  logic [10:0] pair_count_r;
  logic [15:0] capacity_r;
  logic [7:0]  held_r, held_nxt;
  logic        pending_r, pending_nxt;
  logic [15:0] len_r, len_nxt;
  logic        ovf_r, ovf_nxt;
  logic        s1_valid_r, s1_valid_nxt;
  gpe_cmd_t    s1_cmd_r, s1_cmd_nxt;

  logic        op;
  logic [9:0]  idx;
  logic [15:0] e_first, e_second;
  logic [7:0]  tb;
  logic        text_acc, tbl_acc;
  logic [14:0] code, off;
  logic [16:0] off17, idx17, len17, cap17;
  logic        hit, fit2, fit3, fit5;
  logic [31:0] rdata;

  // request fields
  assign op       = in_tuser[0];
  assign idx      = in_tdata[IDX_LSB +: 10];
  assign e_first  = in_tdata[FIRST_LSB +: 16];
  assign e_second = in_tdata[SECOND_LSB +: 16];
  assign tb       = in_tdata[TEXT_LSB +: 8];
  assign text_acc = in_accept && (op == OP_TEXT);
  assign tbl_acc  = in_accept && (op == OP_TABLE);

  // glyph code and window check
  assign code  = {held_r[6:0] & CODE_HI_MASK, tb};
  assign off   = code - first_glyph_r;
  assign off17 = {2'b00, off};
  assign idx17 = {7'd0, idx};
  assign hit   = (pair_count_r != '0) && (code >= first_glyph_r) &&
                 (off < {4'd0, pair_count_r}) && (off17 < DEPTH_L);

  // space checks against capacity
  assign len17 = {1'b0, len_r};
  assign cap17 = {1'b0, capacity_r};
  assign fit2  = (len17 + 17'd2) <= cap17;
  assign fit3  = (len17 + 17'd3) <= cap17;
  assign fit5  = (len17 + 17'd5) <= cap17;

  // pair table
  gpe_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_acc && (idx17 < DEPTH_L)),
    .waddr (idx17[AW-1:0]),
    .wdata ({e_second, e_first}),
    .re    (text_acc),
    .raddr (off17[AW-1:0]),
    .rdata (rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_glyph_r <= '0;
      pair_count_r  <= '0;
      capacity_r    <= CAPACITY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FIRST_GLYPH: first_glyph_r <= cfg_wdata[14:0];
        REG_PAIR_COUNT:  pair_count_r  <= cfg_wdata[10:0];
        REG_CAPACITY:    capacity_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // text byte decode and string state update
  always_comb begin
    held_nxt     = held_r;
    pending_nxt  = pending_r;
    len_nxt      = len_r;
    ovf_nxt      = ovf_r;
    s1_valid_nxt = 1'b0;
    s1_cmd_nxt   = '0;
    if (text_acc) begin
      if (tb == '0) begin
        // terminator, possibly after a lone held lead byte
        s1_valid_nxt       = 1'b1;
        s1_cmd_nxt.term    = 1'b1;
        s1_cmd_nxt.data[0] = held_r;
        if (pending_r && !ovf_r && fit2) begin
          s1_cmd_nxt.cnt = 3'd1;
          s1_cmd_nxt.ovf = 1'b0;
        end else begin
          s1_cmd_nxt.ovf = ovf_r || (pending_r && !ovf_r);
        end
        held_nxt    = '0;
        pending_nxt = 1'b0;
        len_nxt     = '0;
        ovf_nxt     = 1'b0;
      end else if (ovf_r) begin
        pending_nxt = 1'b0;
      end else if (!pending_r) begin
        if (tb[7]) begin
          held_nxt    = tb;
          pending_nxt = 1'b1;
        end else if (fit2) begin
          s1_valid_nxt       = 1'b1;
          s1_cmd_nxt.cnt     = 3'd1;
          s1_cmd_nxt.data[0] = tb;
          len_nxt            = len_r + 16'd1;
        end else begin
          ovf_nxt = 1'b1;
        end
      end else begin
        pending_nxt = 1'b0;
        if (hit) begin
          if (fit5) begin
            s1_valid_nxt    = 1'b1;
            s1_cmd_nxt.cnt  = 3'd4;
            s1_cmd_nxt.pair = 1'b1;
            len_nxt         = len_r + 16'd4;
          end else begin
            ovf_nxt = 1'b1;
          end
        end else if (fit3) begin
          s1_valid_nxt       = 1'b1;
          s1_cmd_nxt.cnt     = 3'd2;
          s1_cmd_nxt.data[0] = held_r;
          s1_cmd_nxt.data[1] = tb;
          len_nxt            = len_r + 16'd2;
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end
  end

  // string state and lookup stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= '0;
      pending_r  <= 1'b0;
      len_r      <= '0;
      ovf_r      <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      held_r     <= held_nxt;
      pending_r  <= pending_nxt;
      len_r      <= len_nxt;
      ovf_r      <= ovf_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd_r <= s1_cmd_nxt;
  end

  // fill pair bytes from the table read
  always_comb begin
    push_cmd = s1_cmd_r;
    if (s1_cmd_r.pair) begin
      push_cmd.data[0] = LEAD_MARK | rdata[15:8];
      push_cmd.data[1] = rdata[7:0];
      push_cmd.data[2] = LEAD_MARK | rdata[31:24];
      push_cmd.data[3] = rdata[23:16];
    end
  end
  assign push = s1_valid_r;

`ifndef SYNTHESIS
  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (text_acc && tb == '0) |=> (!pending_r && len_r == '0 && !ovf_r))
    else $error("terminator did not clear string state");
  a_ovf_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (text_acc && ovf_r && tb != '0) |=> !s1_valid_r)
    else $error("byte emitted after overflow");
`endif

endmodule
`default_nettype wire

@@ src/gpe_queue.sv @@
// Short command queue between the front end and the byte emitter.
// Depends on gpe_pkg.
`default_nettype none
module gpe_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  gpe_pkg::gpe_cmd_t              push_cmd,
  input  logic                           pop,
  output gpe_pkg::gpe_cmd_t              head,
  output logic                           empty,
  output logic [gpe_pkg::QUEUE_CW-1:0]   level
);
  import gpe_pkg::*;

  localparam logic [QUEUE_AW-1:0] LAST_PTR = QUEUE_AW'(QUEUE_DEPTH - 1);
  localparam logic [QUEUE_CW-1:0] FULL_CNT = QUEUE_CW'(QUEUE_DEPTH);

  gpe_cmd_t            mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign level = count_r;

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (count_r < FULL_CNT))
    else $error("command queue overrun");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("command queue underrun");
`endif

endmodule
`default_nettype wire

@@ src/gpe_back.sv @@
// Byte emitter: walks each queued command and drives the output register.
// Depends on gpe_pkg.
`default_nettype none
module gpe_back (
  input  logic              clk,
  input  logic              rst_n,
  input  gpe_pkg::gpe_cmd_t head,
  input  logic              empty,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,   // [7:0] out_byte
  output logic              out_tlast,
  output logic [0:0]        out_tuser    // [0] overflow
);
  import gpe_pkg::*;

  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r, ovf_r;
  logic [2:0] idx_r;
  logic [2:0] total;
  logic       load, in_data;

  // bytes this command yields
  assign total   = head.cnt + {2'b00, head.term};
  assign load    = !empty && (!valid_r || out_tready);
  assign in_data = idx_r < head.cnt;
  assign pop     = load && ((idx_r + 3'd1) == total);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= pop ? 3'd0 : idx_r + 3'd1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_data ? head.data[idx_r[1:0]] : 8'd0;
      last_r <= !in_data;
      ovf_r  <= !in_data && head.ovf;
    end
  end

  assign out_tvalid   = valid_r;
  assign out_tdata    = byte_r;
  assign out_tlast    = last_r;
  assign out_tuser[0] = ovf_r;

`ifndef SYNTHESIS
  a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && last_r) |-> (byte_r == '0))
    else $error("terminator byte is not zero");
`endif

endmodule
`default_nettype wire

@@ src/glyph_pair_expander.sv @@
// Glyph pair expander, top level: front end, command queue, byte emitter.
// Depends on gpe_pkg, gpe_front, gpe_queue, gpe_back.
//
// Takes one request per cycle (table write or text byte) on the in_ stream
// while in_tready is high and emits the expanded string one byte per cycle
// on the out_ stream while out_tready is high. A request is decoded and
// checked against capacity in the front end, which also reads the pair
// table (TABLE_DEPTH x 32, registered read); the read data joins the command
// in the lookup stage, and the resulting command enters a four-entry queue.
// A plain byte yields one output byte, a passed-through pair two, an expanded
// pair four and a terminator one or two; the sustained rate is set by the
// output byte count. in_tready drops while the queue holds three or more
// commands. A request passes the lookup stage, queue and output register.
`default_nettype none
module glyph_pair_expander #(
  parameter int TABLE_DEPTH = gpe_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gpe_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [gpe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [9:0] entry_index, [25:10] entry_first, [41:26] entry_second,
  // [49:42] text_byte, [55:50] zero
  input  logic [gpe_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [0:0]                      in_tuser,   // [0] op
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [7:0] out_byte
  output logic                            out_tlast,
  output logic [0:0]                      out_tuser   // [0] overflow
);
  import gpe_pkg::*;

  localparam logic [QUEUE_CW-1:0] READY_LIMIT = QUEUE_CW'(QUEUE_DEPTH - 1);

  logic                in_accept;
  logic                push, pop, empty;
  gpe_cmd_t            push_cmd, head;
  logic [QUEUE_CW-1:0] level;

  // keep one queue slot for the request in the lookup stage
  assign in_tready = level < READY_LIMIT;
  assign in_accept = in_tvalid && in_tready;

  gpe_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_accept (in_accept),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  gpe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .level    (level)
  );

  gpe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
